### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AFMA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define AFMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define AFMA_ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/afma_pkg.sv
// ---------------------------------------------------------------------------
// afma_pkg
// Types and constants of the angular Fourier mode accumulator.
// ---------------------------------------------------------------------------
package afma_pkg;

    localparam int MODES_DEF   = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int DW          = 32;
    localparam int ACC_W       = 56;
    localparam int MUL_A_W     = 35;
    localparam int MUL_B_W     = 34;
    localparam int PROD_W      = 68;
    localparam int TERM_W      = 38;

    localparam logic [31:0] SCALE_RESET = 32'd1367130551;

    typedef enum logic [1:0] {
        CFG_CENTER_Y = 2'd0,
        CFG_CENTER_Z = 2'd1,
        CFG_SCALE    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic               at_center;
        logic [31:0]        tag;
        logic               last;
    } point_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_SUM,
        ST_ROOT,
        ST_DIV_C,
        ST_DIV_S,
        ST_MODE,
        ST_EMIT
    } back_state_t;

endpackage

### sv/afma_front.sv
// ---------------------------------------------------------------------------
// afma_front
// Accepts points, subtracts the center and flags points at the center.
// ---------------------------------------------------------------------------
module afma_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_pos_y,
    input  logic signed [31:0]    s_pos_z,
    input  logic [31:0]           s_frame_tag,
    input  logic                  s_last_point,
    input  logic signed [31:0]    center_y,
    input  logic signed [31:0]    center_z,
    input  afma_pkg::q_stat_t     q_stat,
    output logic                  push,
    output afma_pkg::point_t      push_data
);
    import afma_pkg::*;

    logic signed [32:0] dy;
    logic signed [32:0] dz;

    assign dy = 33'(s_pos_y) - 33'(center_y);
    assign dz = 33'(s_pos_z) - 33'(center_z);

    assign s_ready = q_stat.not_full;
    assign push    = s_valid && q_stat.not_full;

    always_comb begin
        push_data.dy        = dy;
        push_data.dz        = dz;
        push_data.at_center = (dy == 33'sd0) && (dz == 33'sd0);
        push_data.tag       = s_frame_tag;
        push_data.last      = s_last_point;
    end

endmodule

### sv/afma_queue.sv
// ---------------------------------------------------------------------------
// afma_queue
// Short FIFO of classified points between front and back.
// ---------------------------------------------------------------------------
module afma_queue #(
    parameter int DEPTH = afma_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  afma_pkg::point_t  push_data,
    input  logic              pop,
    output afma_pkg::point_t  pop_data,
    output afma_pkg::q_stat_t q_stat
);
    import afma_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    point_t          entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.not_full  = (count_reg != CW'(DEPTH));
    assign do_push = push && q_stat.not_full;
    assign do_pop  = pop && q_stat.not_empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/afma_back.sv
// ---------------------------------------------------------------------------
// afma_back
// Sequencer: radius, unit direction, mode powers, sums and frame results.
// ---------------------------------------------------------------------------
module afma_back #(
    parameter int MODES = afma_pkg::MODES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  afma_pkg::q_stat_t     q_stat,
    input  afma_pkg::point_t      pop_data,
    output logic                  pop,
    input  logic [31:0]           scale_recip,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_mode_index,
    output logic signed [31:0]    m_real_part,
    output logic signed [31:0]    m_imag_part,
    output logic [31:0]           m_step_tag,
    output logic                  m_last_mode
);
    import afma_pkg::*;

    localparam int MW = (MODES > 1) ? $clog2(MODES) : 1;

    localparam logic [2:0] STEP_0 = 3'd0;
    localparam logic [2:0] STEP_1 = 3'd1;
    localparam logic [2:0] STEP_2 = 3'd2;
    localparam logic [2:0] STEP_3 = 3'd3;
    localparam logic [2:0] STEP_4 = 3'd4;
    localparam logic [2:0] STEP_5 = 3'd5;
    localparam logic [2:0] STEP_LAST = 3'd6;

    localparam logic [5:0] ROOT_STEPS = 6'd32;
    localparam logic [5:0] DIV_STEPS  = 6'd62;

    localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
    localparam logic signed [TERM_W-1:0] LIM_HI = TERM_W'(64'sd1073741824);
    localparam logic signed [TERM_W-1:0] LIM_LO = -TERM_W'(64'sd1073741824);

    back_state_t state_reg, state_next;

    point_t                    pt_reg, pt_next;
    logic [2:0]                step_reg, step_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic [MW-1:0]             mode_reg, mode_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  tmp_reg, tmp_next;
    logic [65:0]               sq_reg, sq_next;
    logic [65:0]               rad_reg, rad_next;
    logic [35:0]               rem_reg, rem_next;
    logic [32:0]               root_reg, root_next;
    logic [62:0]               num_reg, num_next;
    logic [31:0]               quo_reg, quo_next;
    logic signed [31:0]        c_reg, c_next;
    logic signed [31:0]        s_reg, s_next;
    logic signed [31:0]        cn_reg, cn_next;
    logic signed [31:0]        sn_reg, sn_next;
    logic signed [31:0]        nc_reg, nc_next;
    logic [31:0]               lo_reg, lo_next;
    logic signed [31:0]        re_out_reg, re_out_next;

    logic signed [ACC_W-1:0]   re_sums [MODES];
    logic signed [ACC_W-1:0]   im_sums [MODES];

    logic                      m_valid_reg;
    logic [3:0]                m_mode_reg;
    logic signed [31:0]        m_re_reg, m_im_reg;
    logic [31:0]               m_tag_reg;
    logic                      m_last_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [32:0]               ay, az;
    logic                      last_mode;
    logic                      out_load;
    logic                      re_we, im_we, sum_clr;
    logic signed [ACC_W-1:0]   re_wd, im_wd;
    logic signed [ACC_W-1:0]   sel_re, sel_im;
    logic [ACC_W-1:0]          mag_re, mag_im;
    logic signed [31:0]        im_out;

    function automatic logic signed [TERM_W-1:0] rnd30(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + PROD_W'(64'sd536870912);
        return t[PROD_W-1:30];
    endfunction

    function automatic logic signed [31:0] lim_q30(input logic signed [TERM_W-1:0] v);
        logic signed [31:0] r;
        if (v > LIM_HI) begin
            r = ONE_Q30;
        end else if (v < LIM_LO) begin
            r = -ONE_Q30;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [TERM_W-1:0] t);
        logic signed [ACC_W:0] s;
        logic signed [ACC_W-1:0] r;
        s = {a[ACC_W-1], a} + {{(ACC_W + 1 - TERM_W){t[TERM_W-1]}}, t};
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : v;
    endfunction

    function automatic logic signed [31:0] sat_out(input logic neg, input logic [57:0] p);
        logic signed [31:0] r;
        logic [57:0] np;
        np = ~p + 58'd1;
        if (neg) begin
            r = (p > 58'h0_8000_0000) ? 32'sh8000_0000 : np[31:0];
        end else begin
            r = (p > 58'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : p[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] unit_of(input logic neg, input logic [31:0] q);
        logic [31:0] m;
        m = (q > 32'd1073741824) ? 32'd1073741824 : q;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    assign ay = pt_reg.dy[32] ? 33'(-pt_reg.dy) : pt_reg.dy;
    assign az = pt_reg.dz[32] ? 33'(-pt_reg.dz) : pt_reg.dz;
    assign last_mode = (mode_reg == MW'(MODES - 1));
    assign sel_re = re_sums[mode_reg];
    assign sel_im = im_sums[mode_reg];
    assign mag_re = mag_of(sel_re);
    assign mag_im = mag_of(sel_im);
    assign out_load = (state_reg == ST_EMIT) && (step_reg == STEP_LAST)
                      && (!m_valid_reg || m_ready);
    assign pop = (state_reg == ST_IDLE) && q_stat.not_empty;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_stat.not_empty) begin
                    if (!pop_data.at_center) begin
                        state_next = ST_SQ_A;
                    end else if (pop_data.last) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SQ_A:   state_next = ST_SQ_B;
            ST_SQ_B:   state_next = ST_SQ_SUM;
            ST_SQ_SUM: state_next = ST_ROOT;
            ST_ROOT: begin
                if (cnt_reg == ROOT_STEPS) state_next = ST_DIV_C;
            end
            ST_DIV_C: begin
                if (cnt_reg == DIV_STEPS) state_next = ST_DIV_S;
            end
            ST_DIV_S: begin
                if (cnt_reg == DIV_STEPS) state_next = ST_MODE;
            end
            ST_MODE: begin
                if (step_reg == STEP_LAST && last_mode) begin
                    state_next = pt_reg.last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_load && last_mode) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [35:0] rem_sh;
        logic [34:0] trial;
        logic [34:0] dsh;
        pt_next     = pt_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        mode_next   = mode_reg;
        tmp_next    = tmp_reg;
        sq_next     = sq_reg;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        c_next      = c_reg;
        s_next      = s_reg;
        cn_next     = cn_reg;
        sn_next     = sn_reg;
        nc_next     = nc_reg;
        lo_next     = lo_reg;
        re_out_next = re_out_reg;
        im_out      = sat_out(sel_im[ACC_W-1], prod_reg[57:0] + 58'(lo_reg));
        mul_a       = '0;
        mul_b       = '0;
        re_we       = 1'b0;
        im_we       = 1'b0;
        sum_clr     = 1'b0;
        re_wd       = acc_add(sel_re, rnd30(prod_reg));
        im_wd       = acc_add(sel_im, rnd30(prod_reg));
        rem_sh      = {rem_reg[33:0], rad_reg[65:64]};
        trial       = {root_reg, 2'b01};
        dsh         = {rem_reg[33:0], num_reg[62]};
        unique case (state_reg)
            ST_IDLE: begin
                pt_next   = pop_data;
                step_next = STEP_0;
                mode_next = '0;
            end
            ST_SQ_A: begin
                mul_a = $signed({2'b00, ay});
                mul_b = $signed({1'b0, ay});
            end
            ST_SQ_B: begin
                sq_next = prod_reg[65:0];
                mul_a = $signed({2'b00, az});
                mul_b = $signed({1'b0, az});
            end
            ST_SQ_SUM: begin
                rad_next  = sq_reg + prod_reg[65:0];
                rem_next  = '0;
                root_next = '0;
                cnt_next  = '0;
            end
            ST_ROOT: begin
                if (rem_sh >= 36'(trial)) begin
                    rem_next  = rem_sh - 36'(trial);
                    root_next = {root_reg[31:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[31:0], 1'b0};
                end
                rad_next = {rad_reg[63:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_STEPS) begin
                    cnt_next = '0;
                    rem_next = '0;
                    num_next = {ay[32:0], 30'b0} + 63'(root_next[32:1]);
                end
            end
            ST_DIV_C, ST_DIV_S: begin
                if (dsh >= {2'b00, root_reg}) begin
                    rem_next = 36'(dsh - {2'b00, root_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = 36'(dsh);
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                num_next = {num_reg[61:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_STEPS) begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == ST_DIV_C) begin
                        c_next   = unit_of(pt_reg.dy[32], quo_next);
                        num_next = {az[32:0], 30'b0} + 63'(root_reg[32:1]);
                    end else begin
                        s_next    = unit_of(pt_reg.dz[32], quo_next);
                        cn_next   = ONE_Q30;
                        sn_next   = '0;
                        mode_next = '0;
                        step_next = STEP_0;
                    end
                end
            end
            ST_MODE: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    STEP_0: begin
                        mul_a = $signed({2'b00, root_reg});
                        mul_b = MUL_B_W'(cn_reg);
                    end
                    STEP_1: begin
                        re_we = 1'b1;
                        mul_a = $signed({2'b00, root_reg});
                        mul_b = MUL_B_W'(sn_reg);
                    end
                    STEP_2: begin
                        im_we = 1'b1;
                        mul_a = MUL_A_W'(cn_reg);
                        mul_b = MUL_B_W'(c_reg);
                    end
                    STEP_3: begin
                        tmp_next = prod_reg;
                        mul_a = MUL_A_W'(sn_reg);
                        mul_b = MUL_B_W'(s_reg);
                    end
                    STEP_4: begin
                        nc_next = lim_q30(rnd30(tmp_reg - prod_reg));
                        mul_a = MUL_A_W'(sn_reg);
                        mul_b = MUL_B_W'(c_reg);
                    end
                    STEP_5: begin
                        tmp_next = prod_reg;
                        mul_a = MUL_A_W'(cn_reg);
                        mul_b = MUL_B_W'(s_reg);
                    end
                    default: begin
                        sn_next   = lim_q30(rnd30(tmp_reg + prod_reg));
                        cn_next   = nc_reg;
                        step_next = STEP_0;
                        mode_next = last_mode ? '0 : mode_reg + 1'b1;
                    end
                endcase
            end
            ST_EMIT: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    STEP_0: begin
                        mul_a = $signed({3'b000, mag_re[31:0]});
                        mul_b = $signed({2'b00, scale_recip});
                    end
                    STEP_1: begin
                        lo_next = 32'((prod_reg[63:0] + 64'h8000_0000) >> 32);
                        mul_a = $signed({11'b0, mag_re[ACC_W-1:32]});
                        mul_b = $signed({2'b00, scale_recip});
                    end
                    STEP_2: begin
                        re_out_next = sat_out(sel_re[ACC_W-1], prod_reg[57:0] + 58'(lo_reg));
                        mul_a = $signed({3'b000, mag_im[31:0]});
                        mul_b = $signed({2'b00, scale_recip});
                    end
                    STEP_3: begin
                        lo_next = 32'((prod_reg[63:0] + 64'h8000_0000) >> 32);
                        mul_a = $signed({11'b0, mag_im[ACC_W-1:32]});
                        mul_b = $signed({2'b00, scale_recip});
                    end
                    STEP_4: begin
                        tmp_next = PROD_W'(im_out);
                    end
                    STEP_5: begin
                    end
                    default: begin
                        step_next = step_reg;
                        if (out_load) begin
                            sum_clr   = 1'b1;
                            step_next = STEP_0;
                            mode_next = last_mode ? '0 : mode_reg + 1'b1;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_0;
            cnt_reg     <= '0;
            mode_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MODES; i++) begin
                re_sums[i] <= '0;
                im_sums[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            mode_reg  <= mode_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (sum_clr) begin
                re_sums[mode_reg] <= '0;
                im_sums[mode_reg] <= '0;
            end
            if (re_we) re_sums[mode_reg] <= re_wd;
            if (im_we) im_sums[mode_reg] <= im_wd;
        end
    end

    always_ff @(posedge aclk) begin
        pt_reg     <= pt_next;
        prod_reg   <= prod_next;
        tmp_reg    <= tmp_next;
        sq_reg     <= sq_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        c_reg      <= c_next;
        s_reg      <= s_next;
        cn_reg     <= cn_next;
        sn_reg     <= sn_next;
        nc_reg     <= nc_next;
        lo_reg     <= lo_next;
        re_out_reg <= re_out_next;
        if (out_load) begin
            m_mode_reg <= 4'(mode_reg);
            m_re_reg   <= re_out_reg;
            m_im_reg   <= tmp_reg[31:0];
            m_tag_reg  <= pt_reg.tag;
            m_last_reg <= last_mode;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mode_index = m_mode_reg;
    assign m_real_part  = m_re_reg;
    assign m_imag_part  = m_im_reg;
    assign m_step_tag   = m_tag_reg;
    assign m_last_mode  = m_last_reg;

endmodule

### sv/angular_fourier_mode_accumulator_core.sv
// ---------------------------------------------------------------------------
// angular_fourier_mode_accumulator_core
// Per-frame angular Fourier modes of shell points about a set center.
// ---------------------------------------------------------------------------
// Points enter a two-entry queue and are worked one at a time by a single
// sequencer with one shared multiplier. A point at the center is popped and
// adds nothing to the sums. Any other point goes through the pop, the squares,
// a bitwise square root, bitwise restoring divides for cos and sin, and then
// the power and sum steps for each of the MODES modes. After the last point of
// a frame the sequencer scales and hands out the MODES results, and it waits
// while the result side stalls.
module angular_fourier_mode_accumulator_core #(
    parameter int MODES = afma_pkg::MODES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_index,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_pos_z,
    input  logic [31:0]          s_frame_tag,
    input  logic                 s_last_point,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_mode_index,
    output logic signed [31:0]   m_real_part,
    output logic signed [31:0]   m_imag_part,
    output logic [31:0]          m_step_tag,
    output logic                 m_last_mode
);
    import afma_pkg::*;

    logic signed [31:0] center_y_reg;
    logic signed [31:0] center_z_reg;
    logic [31:0]        scale_reg;
    q_stat_t            q_stat;
    point_t             push_data, pop_data;
    logic               push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_y_reg <= '0;
            center_z_reg <= '0;
            scale_reg    <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_CENTER_Y: center_y_reg <= cfg_wr_data;
                CFG_CENTER_Z: center_z_reg <= cfg_wr_data;
                CFG_SCALE:    scale_reg    <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    afma_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_frame_tag  (s_frame_tag),
        .s_last_point (s_last_point),
        .center_y     (center_y_reg),
        .center_z     (center_z_reg),
        .q_stat       (q_stat),
        .push         (push),
        .push_data    (push_data)
    );

    afma_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    afma_back #(.MODES(MODES)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .pop_data     (pop_data),
        .pop          (pop),
        .scale_recip  (scale_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mode_index (m_mode_index),
        .m_real_part  (m_real_part),
        .m_imag_part  (m_imag_part),
        .m_step_tag   (m_step_tag),
        .m_last_mode  (m_last_mode)
    );

endmodule

### sv/afma_checker.sv
// ---------------------------------------------------------------------------
// afma_checker
// Port-level checks on the result channel of the accumulator core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module afma_checker #(
    parameter int MODES = afma_pkg::MODES_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [3:0]           m_mode_index,
    input logic signed [31:0]   m_real_part,
    input logic signed [31:0]   m_imag_part,
    input logic [31:0]          m_step_tag,
    input logic                 m_last_mode
);

    `AFMA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_mode_index) && $stable(m_real_part)
        && $stable(m_imag_part) && $stable(m_step_tag) && $stable(m_last_mode),
        "stalled result request changed")

    `AFMA_ASSERT_IMPL(a_last_is_top, aclk, aresetn, m_valid && m_last_mode,
        m_mode_index == 4'(MODES - 1), "last mode flag on wrong mode")

    `AFMA_ASSERT_IMPL(a_top_is_last, aclk, aresetn,
        (MODES <= 16) && m_valid && (m_mode_index == 4'(MODES - 1)),
        m_last_mode, "top mode without last flag")

    `AFMA_ASSERT_NEXT_ANY(a_reset_idle, aclk, !aresetn, !m_valid,
        "result valid after reset")

endmodule

bind angular_fourier_mode_accumulator_core afma_checker #(.MODES(MODES)) u_afma_checker (.*);

### tb/sv/angular_fourier_mode_accumulator_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// angular_fourier_mode_accumulator_core_tb
// Self-checking bench for the angular Fourier mode accumulator. Shell points
// stream in as frames under several center and scale settings. A bit-exact
// model of the fixed-point math predicts every per-mode result, and each
// result is checked in order while both handshakes idle at random.
// ---------------------------------------------------------------------------
import afma_pkg::*;

typedef struct {
    logic [3:0]  mode;
    logic [31:0] re;
    logic [31:0] im;
    logic [31:0] tag;
    logic        last;
} mode_result_t;

class mode_scoreboard;
    localparam longint ACC_HI = (64'sd1 <<< 55) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 55);
    localparam longint ONE    = 64'sd1 <<< 30;

    longint       cen_y, cen_z;
    logic [63:0]  scl;
    longint       re_acc[MODES_DEF];
    longint       im_acc[MODES_DEF];
    mode_result_t pending_q[$];
    int           errors, mismatches, results, frames;

    function new();
        cen_y = 0;
        cen_z = 0;
        scl   = 64'(SCALE_RESET);
        foreach (re_acc[i]) begin
            re_acc[i] = 0;
            im_acc[i] = 0;
        end
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
        case (idx)
            CFG_CENTER_Y: cen_y = longint'($signed(val));
            CFG_CENTER_Z: cen_z = longint'($signed(val));
            CFG_SCALE:    scl   = 64'(val);
            default: ;
        endcase
    endfunction

    function logic [63:0] isqrt(logic [65:0] v);
        logic [63:0] rem, root, trial;
        rem  = 0;
        root = 0;
        for (int i = 32; i >= 0; i--) begin
            rem   = (rem << 2) | 64'(v[2*i+1 -: 2]);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function longint unit_dir(longint d, logic [63:0] r);
        logic [63:0] mag, q;
        mag = (d < 0) ? -d : d;
        q   = ((mag << 30) + (r >> 1)) / r;
        if (q > 64'(ONE)) q = 64'(ONE);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint rnd30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint clip_q30(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function longint acc_sat(longint a, longint t);
        longint v;
        v = a + t;
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function logic [31:0] scale_sum(longint sum);
        logic [63:0] m, p, nv;
        m = (sum < 0) ? -sum : sum;
        p = (m >> 32) * scl + (((m & 64'hFFFF_FFFF) * scl + 64'h8000_0000) >> 32);
        nv = -p;
        if (sum < 0) return (p > 64'h8000_0000) ? 32'h8000_0000 : nv[31:0];
        return (p > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
    endfunction

    function void note_point(logic signed [31:0] y, logic signed [31:0] z,
                             logic [31:0] tag, logic last);
        longint       dy, dz, c, s, cn, sn, nc, ns, rs;
        logic [65:0]  ay, az;
        logic [63:0]  r;
        mode_result_t e;
        dy = longint'(y) - cen_y;
        dz = longint'(z) - cen_z;
        ay = (dy < 0) ? 66'(-dy) : 66'(dy);
        az = (dz < 0) ? 66'(-dz) : 66'(dz);
        r  = isqrt(ay * ay + az * az);
        if (r != 0) begin
            c  = unit_dir(dy, r);
            s  = unit_dir(dz, r);
            cn = ONE;
            sn = 0;
            rs = longint'(r);
            for (int n = 0; n < MODES_DEF; n++) begin
                re_acc[n] = acc_sat(re_acc[n], rnd30(rs * cn));
                im_acc[n] = acc_sat(im_acc[n], rnd30(rs * sn));
                nc = clip_q30(rnd30(cn * c - sn * s));
                ns = clip_q30(rnd30(sn * c + cn * s));
                cn = nc;
                sn = ns;
            end
        end
        if (!last) return;
        frames++;
        for (int n = 0; n < MODES_DEF; n++) begin
            e.mode = 4'(n);
            e.re   = scale_sum(re_acc[n]);
            e.im   = scale_sum(im_acc[n]);
            e.tag  = tag;
            e.last = (n == MODES_DEF - 1);
            pending_q.push_back(e);
            re_acc[n] = 0;
            im_acc[n] = 0;
        end
    endfunction

    function void check_result(mode_result_t a);
        mode_result_t e;
        results++;
        if (pending_q.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: mode %0d re %h im %h", a.mode, a.re, a.im);
            return;
        end
        e = pending_q.pop_front();
        if (a.mode !== e.mode || a.re !== e.re || a.im !== e.im ||
            a.tag !== e.tag || a.last !== e.last) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp mode %0d re %h im %h tag %h last %b",
                         e.mode, e.re, e.im, e.tag, e.last);
                $display("          got mode %0d re %h im %h tag %h last %b",
                         a.mode, a.re, a.im, a.tag, a.last);
            end
        end
    endfunction
endclass

module angular_fourier_mode_accumulator_core_tb;
    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_wr_index = 2'd0;
    logic [31:0]         cfg_wr_data = 32'd0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic signed [31:0]  s_pos_y = 32'sd0;
    logic signed [31:0]  s_pos_z = 32'sd0;
    logic [31:0]         s_frame_tag = 32'd0;
    logic                s_last_point = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [3:0]          m_mode_index;
    logic signed [31:0]  m_real_part;
    logic signed [31:0]  m_imag_part;
    logic [31:0]         m_step_tag;
    logic                m_last_mode;

    mode_scoreboard sb = new();
    int burst_left = 0;
    int stall_mode = 0;
    int stall_cnt  = 0;
    int points     = 0;

    angular_fourier_mode_accumulator_core u_dut (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        mode_result_t a;
        if (aresetn && m_valid && m_ready) begin
            a.mode = m_mode_index;
            a.re   = m_real_part;
            a.im   = m_imag_part;
            a.tag  = m_step_tag;
            a.last = m_last_mode;
            sb.check_result(a);
        end
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_cnt  = $urandom_range(50, 400);
        end
        stall_cnt--;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_regs(logic [31:0] cy, logic [31:0] cz, logic [31:0] sc);
        cfg_idx_t    idx[3] = '{CFG_CENTER_Y, CFG_CENTER_Z, CFG_SCALE};
        logic [31:0] val[3];
        val = '{cy, cz, sc};
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= idx[i];
            cfg_wr_data  <= val[i];
            sb.set_reg(idx[i], val[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_point(logic [31:0] y, logic [31:0] z, logic [31:0] tag, logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_pos_y      <= y;
        s_pos_z      <= z;
        s_frame_tag  <= tag;
        s_last_point <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_point(y, z, tag, last);
        points++;
    endtask

    // hold off until every result is out and the core has gone quiet
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic random_frames(int npts, int cy, int cz);
        int          left, k;
        logic [31:0] y, z;
        left = 0;
        for (int i = 0; i < npts; i++) begin
            if (left == 0) left = $urandom_range(1, 6);
            k = $urandom_range(0, 9);
            if (k == 0) begin
                y = cy;
                z = cz;
            end else if (k < 4) begin
                y = $urandom;
                z = $urandom;
            end else begin
                y = cy + $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                z = cz + $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            end
            left--;
            send_point(y, z, $urandom, (left == 0) || (i == npts - 1));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_regs(32'd0, 32'd0, SCALE_RESET);
        send_point(32'd0, 32'd0, 32'd0, 1'b1);
        send_point(32'h7FFF_FFFF, 32'd0, 32'd1, 1'b0);
        send_point(32'h8000_0000, 32'd0, 32'd2, 1'b0);
        send_point(32'd0, 32'h7FFF_FFFF, 32'd3, 1'b0);
        send_point(32'd0, 32'h8000_0000, 32'd4, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h5, 1'b0);
        send_point(32'd1, 32'd0, 32'h6, 1'b0);
        send_point(32'd0, 32'd1, 32'h7, 1'b0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8, 1'b0);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h9, 1'b1);
        drain();

        write_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hA, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hB, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hC, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'hD, 1'b1);
        random_frames(30, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        write_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hE, 1'b1);
        random_frames(20, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        write_regs($urandom, $urandom, $urandom);
        random_frames(60, int'(sb.cen_y), int'(sb.cen_z));
        drain();

        write_regs(32'h0010_0000, 32'hFFF0_0000, SCALE_RESET);
        random_frames(70, 32'h0010_0000, 32'hFFF0_0000);
        drain();

        $display("covered %0d points in %0d frames, %0d mode results",
                 points, sb.frames, sb.results);
        $display("over five register settings with random stalls on both sides");
        if (sb.pending_q.size() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d errors", sb.errors);
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end
endmodule
